FILE: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared widths, character codes and pipeline payload type for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int MAG_W          = 32;            // input word / magnitude width
    localparam int DIGITS         = 10;            // decimal digits of a 32-bit magnitude
    localparam int BCD_W          = 4 * DIGITS;
    localparam int IDX_W          = 4;             // digit index, 0..DIGITS-1
    localparam int CHAR_W         = 8;
    localparam int BITS_PER_STAGE = 4;             // default binary bits per conversion stage

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Word moving down the conversion pipeline
    typedef struct packed {
        logic             neg;   // value was negative
        logic [BCD_W-1:0] bcd;   // packed BCD digits, digit 0 in the low nibble
        logic [MAG_W-1:0] bin;   // binary bits still to be shifted in, MSB first
    } conv_t;

endpackage

FILE: rtl/sitda_dabble_stage.sv
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// One registered stage of the shift-and-add-3 binary to BCD conversion.
// Consumes STEPS binary bits per word, with a valid/ready handshake.
// ----------------------------------------------------------------------------
module sitda_dabble_stage
    import sitda_pkg::*;
#(
    parameter int STEPS = BITS_PER_STAGE
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  conv_t s_data,
    output logic  m_valid,
    input  logic  m_ready,
    output conv_t m_data
);

    logic  valid_reg;
    conv_t data_reg;
    conv_t data_next;

    always_comb
    begin
        logic [BCD_W-1:0] bcd;
        logic [MAG_W-1:0] bin;
        bcd = s_data.bcd;
        bin = s_data.bin;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd[d*4 +: 4] >= 4'd5)
                begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[MAG_W-1]};
            bin = {bin[MAG_W-2:0], 1'b0};
        end
        data_next.neg = s_data.neg;
        data_next.bcd = bcd;
        data_next.bin = bin;
    end

    assign s_ready = !valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: rtl/sitda_serializer.sv
// ----------------------------------------------------------------------------
// sitda_serializer
// Turns one converted word (sign + BCD digits) into a run of ASCII
// characters, leading zeros dropped, last character flagged.
// ----------------------------------------------------------------------------
module sitda_serializer
    import sitda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  conv_t             s_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic                       busy_reg;
    logic                       sign_pending_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [DIGITS-1:0][3:0]     digits_reg;
    logic                       out_valid_reg;
    logic [CHAR_W-1:0]          char_reg;
    logic                       last_reg;

    logic [DIGITS-1:0][3:0]     in_digits;
    logic [IDX_W-1:0]           top_idx;
    logic                       out_free;
    logic                       emit;
    logic                       emit_last;
    logic                       load;
    logic [3:0]                 cur_digit;

    assign in_digits = s_data.bcd;

    // highest nonzero digit; zero gives a single '0'
    always_comb
    begin
        top_idx = '0;
        for (int i = 1; i < DIGITS; i++)
        begin
            if (in_digits[i] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = digits_reg[idx_reg];
    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = busy_reg && out_free;
    assign emit_last = emit && !sign_pending_reg && (idx_reg == '0);
    assign s_ready   = !busy_reg || emit_last;
    assign load      = s_valid && s_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            sign_pending_reg <= 1'b0;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // while busy, a load only coincides with the last character of the run
            if (load)
            begin
                busy_reg         <= 1'b1;
                sign_pending_reg <= s_data.neg;
                idx_reg          <= top_idx;
            end
            else if (emit)
            begin
                if (sign_pending_reg)
                begin
                    sign_pending_reg <= 1'b0;
                end
                else if (idx_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= in_digits;
        end
        if (emit)
        begin
            if (sign_pending_reg)
            begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
            end
            else
            begin
                char_reg <= CHAR_ZERO + {4'd0, cur_digit};
                last_reg <= (idx_reg == '0);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    a_last_not_minus : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata != CHAR_MINUS)
        else $error("minus sign flagged as last character");

    a_char_code : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == CHAR_MINUS) ||
                     ((m_tdata >= CHAR_ZERO) && (m_tdata <= CHAR_NINE)))
        else $error("character outside minus and digits");

    a_load_only_at_end : assert property (@(posedge clk) disable iff (!rst_n)
        load && busy_reg |-> emit_last)
        else $error("new word loaded while a run is in progress");

    a_sign_needs_busy : assert property (@(posedge clk) disable iff (!rst_n)
        sign_pending_reg |-> busy_reg)
        else $error("sign pending with no active run");

    a_emit_shows : assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("emitted character not presented");

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per word.
// ----------------------------------------------------------------------------
// Each input word is a 32-bit two's complement integer; the output is its
// decimal text, most significant digit first, no leading zeros, a leading
// '-' for negative values (the most negative value included), and tlast on
// the final character. A value yields 1 to 11 characters; the character
// serializer is the bottleneck, sending one character per cycle while
// m_tready allows it and taking the next value in the cycle its last
// character is sent. Ahead of it a register for sign and magnitude and
// MAG_W/BITS_PER_STAGE shift-and-add-3 stages (8 by default) lie before the
// character register that drives m_tdata; the pipeline holds further values
// meanwhile, and backpressure stalls it without loss.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int BITS_PER_STAGE_P = BITS_PER_STAGE   // must divide MAG_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [MAG_W-1:0]  s_tdata,    // [31:0] value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,    // [7:0] character
    output logic              m_tlast
);

    localparam int NUM_STAGES = MAG_W / BITS_PER_STAGE_P;

    logic                  in_valid_reg;
    conv_t                 in_data_reg;
    conv_t                 in_data_next;

    logic  [NUM_STAGES:0]  st_valid;
    logic  [NUM_STAGES:0]  st_ready;
    conv_t                 st_data [NUM_STAGES+1];

    // sign and magnitude; 0 - x in 32 bits handles the most negative value
    always_comb
    begin
        in_data_next.neg = s_tdata[MAG_W-1];
        in_data_next.bcd = '0;
        in_data_next.bin = s_tdata[MAG_W-1] ? (~s_tdata + MAG_W'(1)) : s_tdata;
    end

    assign s_tready = !in_valid_reg || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= in_data_next;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_data[0]  = in_data_reg;

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        sitda_dabble_stage #(
            .STEPS (BITS_PER_STAGE_P)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .s_valid (st_valid[g]),
            .s_ready (st_ready[g]),
            .s_data  (st_data[g]),
            .m_valid (st_valid[g+1]),
            .m_ready (st_ready[g+1]),
            .m_data  (st_data[g+1])
        );
    end

    sitda_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (st_valid[NUM_STAGES]),
        .s_ready  (st_ready[NUM_STAGES]),
        .s_data   (st_data[NUM_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
